FILE: src/s2luv_pkg.sv
// Constants, coefficient tables and the sRGB linearization table for the sRGB to L*u*v* unit.
// Used by srgb_to_luv_byte_codes_unit; depends on nothing else.
package s2luv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int LIN_BITS     = 17;   // Q0.16, 1.0 needs bit 16
    localparam int XYZ_BITS     = 33;   // Q32, Y reaches 2^32
    localparam int DEN_BITS     = 37;   // X + 15Y + 3Z
    localparam int QUO_BITS     = 27;   // u' up to 4.0 in Q24
    localparam int DIV_STEPS    = QUO_BITS;
    localparam int ROOT_BITS    = 21;   // cube root in Q20
    localparam int WORK_BITS    = 64;
    localparam int CUBE_BITS    = 66;
    localparam int SMALL_BITS   = 24;
    localparam int L_BITS       = 24;   // signed L* in Q16
    localparam int CHROMA_BITS  = 28;

    localparam logic [15:0] MAT_Q16 [3][3] = '{
        '{16'd28577, 16'd25237, 16'd9377},
        '{16'd14581, 16'd46982, 16'd3973},
        '{16'd913,   16'd6363,  16'd46805}
    };

    localparam longint unsigned WHITE_X = 64'd63191;
    localparam longint unsigned WHITE_Y = 64'd65536;
    localparam longint unsigned WHITE_Z = 64'd54081;
    localparam longint unsigned WDEN    = WHITE_X + 64'd15 * WHITE_Y + 64'd3 * WHITE_Z;
    localparam longint unsigned UR_FULL = ((64'd4 * WHITE_X) << 24) / WDEN;
    localparam longint unsigned VR_FULL = ((64'd9 * WHITE_Y) << 24) / WDEN;
    localparam logic [QUO_BITS-1:0] UR_Q24 = UR_FULL[QUO_BITS-1:0];
    localparam logic [QUO_BITS-1:0] VR_Q24 = VR_FULL[QUO_BITS-1:0];

    localparam logic [47:0] EPS_LIMIT = 48'd216 << 32;
    localparam logic [14:0] KAPPA_NUM = 15'd24389;
    // floor(n / 27) = (n * RECIP_27) >> 29 for n below 2^24
    localparam logic [24:0] RECIP_27  = 25'd19884108;
    // floor(n / 100) = (n * RECIP_100) >> 22 for n below 2^15
    localparam logic [15:0] RECIP_100 = 16'd41944;
    localparam logic [31:0] L_ROUND   = 32'd3276800;
    localparam logic [7:0]  U_OFFSET  = 8'd84;
    localparam logic [7:0]  V_OFFSET  = 8'd124;

    typedef logic [LIN_BITS-1:0] lin_table_t [256];

    function automatic longint unsigned fifth_q30(longint unsigned r);
        longint unsigned r2;
        longint unsigned r4;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        return (r4 * r) >> 30;
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t      tbl;
        longint unsigned c;
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        longint unsigned cand;
        longint unsigned v;
        for (int i = 0; i < 256; i++) begin
            c = longint'(i);
            if (c * 64'd100000 <= 64'd1031475) begin
                v = (c * 64'd6553600 + 64'd164730) / 64'd329460;
            end else begin
                t = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
                if (t > (64'd1 << 30)) t = 64'd1 << 30;
                s = (t * t) >> 30;
                r = 64'd0;
                for (int b = 30; b >= 0; b--) begin
                    cand = r | (64'd1 << b);
                    if (cand <= (64'd1 << 30) && fifth_q30(cand) <= s) r = cand;
                end
                v = (((s * r) >> 30) + 64'd8192) >> 14;
            end
            tbl[i] = v[LIN_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

    typedef struct packed {
        logic [WORK_BITS-1:0] rem_u;
        logic [WORK_BITS-1:0] rem_v;
        logic [DEN_BITS-1:0]  den;
        logic [QUO_BITS-1:0]  quo_u;
        logic [QUO_BITS-1:0]  quo_v;
        logic [WORK_BITS-1:0] cube_in;
        logic [ROOT_BITS-1:0] root;
        logic [41:0]          root_sq;
        logic [WORK_BITS-1:0] root_cu;
        logic                 big;
        logic [SMALL_BITS-1:0] small_n;
        logic                 black;
    } div_stage_t;

endpackage

FILE: src/srgb_to_luv_byte_codes_unit.sv
// sRGB pixel to L*u*v* byte codes (D50 white), fully pipelined.
// Depends on s2luv_pkg for constants, the linearization table and the stage record.
//
// One pixel in and one result out per clock while the result side accepts.
// The depth is set by the 27-step restoring dividers for u' and v', which run
// beside the 21-step cube root for L*. A stall on the result side freezes the
// whole pipe; nothing is dropped or repeated. Black gives u_code 84, v_code 124.
module srgb_to_luv_byte_codes_unit
    import s2luv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // lightness_code [7:0], u_code [15:8], v_code [23:16]
);

    logic advance;
    assign advance  = m_tready || !m_tvalid;
    assign s_tready = advance && aresetn;

    // stage 1: table lookup
    logic                v1_reg;
    logic [LIN_BITS-1:0] lin_reg [3];

    // stage 2: matrix
    logic                v2_reg;
    logic [XYZ_BITS-1:0] x_reg, y_reg, z_reg;
    logic [XYZ_BITS-1:0] x_next, y_next, z_next;

    // stage 3 and divider / cube root steps
    logic       dv_reg   [DIV_STEPS+1];
    div_stage_t dpipe_reg [DIV_STEPS+1];
    div_stage_t dpipe_next [DIV_STEPS+1];

    // post stages
    logic                     va_reg, vb_reg, vc_reg;
    logic signed [L_BITS-1:0] l_a_reg, l_a_next;
    logic [QUO_BITS-1:0]      up_a_reg, vp_a_reg;
    logic                     black_a_reg, black_b_reg, black_c_reg;
    logic signed [CHROMA_BITS-1:0] m13_b_reg, du_b_reg, dv_b_reg;
    logic [31:0]              lp_b_reg;
    logic signed [55:0]       val_u_c_reg, val_v_c_reg;
    logic [7:0]               lcode_c_reg;
    logic                     m_tvalid_reg;
    logic [23:0]              m_tdata_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        x_next = XYZ_BITS'(MAT_Q16[0][0]) * XYZ_BITS'(lin_reg[0])
               + XYZ_BITS'(MAT_Q16[0][1]) * XYZ_BITS'(lin_reg[1])
               + XYZ_BITS'(MAT_Q16[0][2]) * XYZ_BITS'(lin_reg[2]);
        y_next = XYZ_BITS'(MAT_Q16[1][0]) * XYZ_BITS'(lin_reg[0])
               + XYZ_BITS'(MAT_Q16[1][1]) * XYZ_BITS'(lin_reg[1])
               + XYZ_BITS'(MAT_Q16[1][2]) * XYZ_BITS'(lin_reg[2]);
        z_next = XYZ_BITS'(MAT_Q16[2][0]) * XYZ_BITS'(lin_reg[0])
               + XYZ_BITS'(MAT_Q16[2][1]) * XYZ_BITS'(lin_reg[1])
               + XYZ_BITS'(MAT_Q16[2][2]) * XYZ_BITS'(lin_reg[2]);
    end

    // set up division numerators, eps test and cube root input
    logic [47:0] kappa_prod;
    always_comb begin
        kappa_prod = 48'(y_reg) * 48'(KAPPA_NUM);
        dpipe_next[0]         = '0;
        dpipe_next[0].den     = DEN_BITS'(x_reg) + DEN_BITS'(y_reg) * DEN_BITS'(15)
                              + DEN_BITS'(z_reg) * DEN_BITS'(3);
        dpipe_next[0].rem_u   = WORK_BITS'(x_reg) << 26;
        dpipe_next[0].rem_v   = (WORK_BITS'(y_reg) * WORK_BITS'(9)) << 24;
        dpipe_next[0].cube_in = WORK_BITS'(y_reg) << 28;
        dpipe_next[0].big     = kappa_prod > EPS_LIMIT;
        dpipe_next[0].small_n = kappa_prod[16 +: SMALL_BITS];
        dpipe_next[0].black   = (x_reg == '0) && (y_reg == '0) && (z_reg == '0);
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        localparam int QB = QUO_BITS - 1 - i;
        localparam int RB = (i < ROOT_BITS) ? ROOT_BITS - 1 - i : 0;
        logic [WORK_BITS-1:0] dshift;
        logic [CUBE_BITS-1:0] cand_cu;
        logic [41:0]          cand_sq;
        always_comb begin
            dshift = WORK_BITS'(dpipe_reg[i].den) << QB;
            cand_cu = CUBE_BITS'(dpipe_reg[i].root_cu)
                    + ((CUBE_BITS'(dpipe_reg[i].root_sq) * CUBE_BITS'(3)) << RB)
                    + ((CUBE_BITS'(dpipe_reg[i].root) * CUBE_BITS'(3)) << (2 * RB))
                    + (CUBE_BITS'(1) << (3 * RB));
            cand_sq = dpipe_reg[i].root_sq + (42'(dpipe_reg[i].root) << (RB + 1))
                    + (42'(1) << (2 * RB));
            dpipe_next[i+1] = dpipe_reg[i];
            if (dpipe_reg[i].rem_u >= dshift) begin
                dpipe_next[i+1].rem_u     = dpipe_reg[i].rem_u - dshift;
                dpipe_next[i+1].quo_u[QB] = 1'b1;
            end
            if (dpipe_reg[i].rem_v >= dshift) begin
                dpipe_next[i+1].rem_v     = dpipe_reg[i].rem_v - dshift;
                dpipe_next[i+1].quo_v[QB] = 1'b1;
            end
            // cube root bits resolve only in the first ROOT_BITS steps
            if (i < ROOT_BITS && cand_cu <= CUBE_BITS'(dpipe_reg[i].cube_in)) begin
                dpipe_next[i+1].root    = dpipe_reg[i].root | (ROOT_BITS'(1) << RB);
                dpipe_next[i+1].root_sq = cand_sq;
                dpipe_next[i+1].root_cu = cand_cu[WORK_BITS-1:0];
            end
        end
        always_ff @(posedge aclk) begin
            if (advance) dpipe_reg[i+1] <= dpipe_next[i+1];
        end
    end

    // L* from either branch
    logic [27:0] l116;
    logic [48:0] small_prod;
    always_comb begin
        l116       = 28'(dpipe_reg[DIV_STEPS].root) * 28'd116;
        small_prod = 49'(dpipe_reg[DIV_STEPS].small_n) * 49'(RECIP_27);
        if (dpipe_reg[DIV_STEPS].big) begin
            l_a_next = $signed({1'b0, l116[26:4]}) - L_BITS'(1 << 20);
        end else begin
            l_a_next = $signed(L_BITS'(small_prod[48:29]));
        end
    end

    logic [L_BITS-2:0] l_clamp;
    assign l_clamp = l_a_reg[L_BITS-1] ? '0 : l_a_reg[L_BITS-2:0];

    logic [31:0] lq_prod;
    assign lq_prod = 32'(lp_b_reg[31:16]) * 32'(RECIP_100);

    logic [7:0] u_code, v_code;
    always_comb begin
        u_code = val_u_c_reg[47:40] + 8'(val_u_c_reg[39]) + U_OFFSET;
        v_code = val_v_c_reg[47:40] + 8'(val_v_c_reg[39]) + V_OFFSET;
        if (black_c_reg) begin
            u_code = U_OFFSET;
            v_code = V_OFFSET;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) dv_reg[k] <= 1'b0;
        end else if (advance) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int k = 0; k < DIV_STEPS; k++) dv_reg[k+1] <= dv_reg[k];
            va_reg       <= dv_reg[DIV_STEPS];
            vb_reg       <= va_reg;
            vc_reg       <= vb_reg;
            m_tvalid_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lin_reg[0]   <= LIN_TABLE[s_tdata[7:0]];
            lin_reg[1]   <= LIN_TABLE[s_tdata[15:8]];
            lin_reg[2]   <= LIN_TABLE[s_tdata[23:16]];
            x_reg        <= x_next;
            y_reg        <= y_next;
            z_reg        <= z_next;
            dpipe_reg[0] <= dpipe_next[0];
            l_a_reg      <= l_a_next;
            up_a_reg     <= dpipe_reg[DIV_STEPS].quo_u;
            vp_a_reg     <= dpipe_reg[DIV_STEPS].quo_v;
            black_a_reg  <= dpipe_reg[DIV_STEPS].black;
            m13_b_reg    <= CHROMA_BITS'(l_a_reg) * CHROMA_BITS'(13);
            du_b_reg     <= $signed({1'b0, up_a_reg}) - $signed({1'b0, UR_Q24});
            dv_b_reg     <= $signed({1'b0, vp_a_reg}) - $signed({1'b0, VR_Q24});
            lp_b_reg     <= 32'(l_clamp) * 32'd255 + L_ROUND;
            black_b_reg  <= black_a_reg;
            val_u_c_reg  <= 56'(m13_b_reg) * 56'(du_b_reg);
            val_v_c_reg  <= 56'(m13_b_reg) * 56'(dv_b_reg);
            lcode_c_reg  <= lq_prod[29:22];
            black_c_reg  <= black_b_reg;
            m_tdata_reg  <= {v_code, u_code, lcode_c_reg};
        end
    end

    a_cube_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg[DIV_STEPS] |-> dpipe_reg[DIV_STEPS].root_cu <= dpipe_reg[DIV_STEPS].cube_in)
        else $error("cube root overshoots its input");

    a_u_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_reg[DIV_STEPS] && !dpipe_reg[DIV_STEPS].black)
        |-> dpipe_reg[DIV_STEPS].quo_u <= QUO_BITS'(1 << 26))
        else $error("u prime above 4.0");

    a_rem_u: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_reg[DIV_STEPS] && !dpipe_reg[DIV_STEPS].black)
        |-> dpipe_reg[DIV_STEPS].rem_u < WORK_BITS'(dpipe_reg[DIV_STEPS].den))
        else $error("u division remainder not below divisor");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(dv_reg[0]) && $stable(va_reg))
        else $error("pipe moved during stall");

endmodule
